@@ rtl/core/kmna_pkg.sv @@
// Shared types, constants and helpers of the k-means nearest-centre assignment unit.
`default_nettype none
package kmna_pkg;

  localparam int MAX_CENTERS = 16;
  localparam int MAX_DIMS    = 8;
  localparam int COORD_WIDTH = 16;

  localparam int IN_COORD_WIDTH = 16;
  localparam int SLOT_WIDTH     = 4;
  localparam int LABEL_WIDTH    = 4;
  localparam int DIST_WIDTH     = 35;
  localparam int AC_WIDTH       = 5;
  localparam int AD_WIDTH       = 4;
  localparam int ADDR_WIDTH     = 3;
  localparam int DATA_WIDTH     = 32;

  localparam int ROW_BITS   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int CNT_WIDTH  = $clog2(MAX_CENTERS + 1);
  localparam int DIM_WIDTH  = $clog2(MAX_DIMS + 1);
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  localparam int SQ_WIDTH   = 2 * DIFF_WIDTH;
  localparam int SUM_WIDTH  = SQ_WIDTH + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  localparam logic REG_ACTIVE_CENTERS = 1'b0;
  localparam logic REG_ACTIVE_DIMS    = 1'b1;

  localparam logic [AC_WIDTH-1:0] ACTIVE_CENTERS_RESET = AC_WIDTH'(1);
  localparam logic [AD_WIDTH-1:0] ACTIVE_DIMS_RESET    = AD_WIDTH'(8);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] row_t;
  typedef logic signed [IN_COORD_WIDTH-1:0] in_coord_t;

  typedef struct packed {
    logic                load_wr;
    logic                point_ld;
    logic                issue;
    logic [ROW_BITS-1:0] issue_idx;
    logic                out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

  function automatic coord_t to_coord(input in_coord_t x);
    return COORD_WIDTH'(x);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/kmna_regs.sv @@
// Configuration register file with an APB-style access port.
`default_nettype none
module kmna_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [kmna_pkg::ADDR_WIDTH-1:0]   paddr,
  input  wire logic [kmna_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic      [kmna_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                                   pready,
  output logic      [kmna_pkg::AC_WIDTH-1:0]     active_centers,
  output logic      [kmna_pkg::AD_WIDTH-1:0]     active_dims
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_centers <= kmna_pkg::ACTIVE_CENTERS_RESET;
      active_dims    <= kmna_pkg::ACTIVE_DIMS_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        kmna_pkg::REG_ACTIVE_CENTERS: active_centers <= pwdata[kmna_pkg::AC_WIDTH-1:0];
        kmna_pkg::REG_ACTIVE_DIMS:    active_dims    <= pwdata[kmna_pkg::AD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kmna_pkg::REG_ACTIVE_CENTERS: prdata = kmna_pkg::DATA_WIDTH'(active_centers);
      kmna_pkg::REG_ACTIVE_DIMS:    prdata = kmna_pkg::DATA_WIDTH'(active_dims);
      default:                      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/kmna_dpath.sv @@
// Datapath: centre store, distance lanes, adder tree, minimum tracking and output register.
`default_nettype none
module kmna_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire kmna_pkg::ctrl_cmd_t                  cmd,
  output kmna_pkg::dp_status_t                      status,
  input  wire logic [kmna_pkg::SLOT_WIDTH-1:0]      center_slot,
  input  wire kmna_pkg::in_coord_t                  coord [kmna_pkg::MAX_DIMS],
  input  wire logic [kmna_pkg::AD_WIDTH-1:0]        active_dims,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [kmna_pkg::LABEL_WIDTH-1:0]     label,
  output logic      [kmna_pkg::DIST_WIDTH-1:0]      min_distance
);

  kmna_pkg::row_t mem [kmna_pkg::MAX_CENTERS];
  kmna_pkg::row_t wr_row;
  kmna_pkg::row_t rd_row;
  kmna_pkg::row_t point;

  logic [kmna_pkg::DIM_WIDTH-1:0] dims;
  logic                           slot_ok;

  logic                           v1, v2, v3;
  logic [kmna_pkg::ROW_BITS-1:0]  idx1, idx2, idx3;
  logic [kmna_pkg::SQ_WIDTH-1:0]  sq [kmna_pkg::MAX_DIMS];
  logic [kmna_pkg::SQ_WIDTH-1:0]  sq_next [kmna_pkg::MAX_DIMS];
  logic [kmna_pkg::SUM_WIDTH-1:0] sum_all;
  logic [kmna_pkg::DIST_WIDTH-1:0] row_dist;
  logic [kmna_pkg::DIST_WIDTH-1:0] row_dist_next;
  logic [kmna_pkg::DIST_WIDTH-1:0] best;
  logic [kmna_pkg::ROW_BITS-1:0]  best_idx;

  always_comb begin
    for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) begin
      wr_row[i] = kmna_pkg::to_coord(coord[i]);
    end
  end

  assign slot_ok = ({1'b0, center_slot} < (kmna_pkg::SLOT_WIDTH + 1)'(kmna_pkg::MAX_CENTERS));

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      mem[center_slot[kmna_pkg::ROW_BITS-1:0]] <= wr_row;
    end
    if (cmd.issue) begin
      rd_row <= mem[cmd.issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.point_ld) begin
      point <= wr_row;
    end
  end

  assign dims = ({1'b0, active_dims} > (kmna_pkg::AD_WIDTH + 1)'(kmna_pkg::MAX_DIMS))
              ? kmna_pkg::DIM_WIDTH'(kmna_pkg::MAX_DIMS)
              : kmna_pkg::DIM_WIDTH'(active_dims);

  always_comb begin
    logic signed [kmna_pkg::DIFF_WIDTH-1:0] d;
    logic signed [kmna_pkg::SQ_WIDTH-1:0]   p;
    for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) begin
      d = kmna_pkg::DIFF_WIDTH'($signed(point[i])) - kmna_pkg::DIFF_WIDTH'($signed(rd_row[i]));
      p = d * d;
      if ((kmna_pkg::DIM_WIDTH + 1)'(i) < {1'b0, dims}) begin
        sq_next[i] = $unsigned(p);
      end else begin
        sq_next[i] = '0;
      end
    end
  end

  always_comb begin
    sum_all = '0;
    for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) begin
      sum_all = sum_all + kmna_pkg::SUM_WIDTH'(sq[i]);
    end
    if (sum_all > kmna_pkg::SUM_WIDTH'(kmna_pkg::DIST_MAX)) begin
      row_dist_next = kmna_pkg::DIST_MAX;
    end else begin
      row_dist_next = kmna_pkg::DIST_WIDTH'(sum_all);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1     <= cmd.issue_idx;
    idx2     <= idx1;
    idx3     <= idx2;
    sq       <= sq_next;
    row_dist <= row_dist_next;
    if (v3 && ((idx3 == '0) || (row_dist < best))) begin
      best     <= row_dist;
      best_idx <= idx3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      label        <= kmna_pkg::LABEL_WIDTH'(best_idx);
      min_distance <= best;
    end
  end

  assign status.pipe_busy = v1 || v2 || v3;
  assign status.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

@@ rtl/core/kmna_ctrl.sv @@
// Controller state machine that sequences centre rows through the datapath.
`default_nettype none
module kmna_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              func,
  input  wire logic [kmna_pkg::AC_WIDTH-1:0]     active_centers,
  input  wire kmna_pkg::dp_status_t              status,
  output kmna_pkg::ctrl_cmd_t                    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                     state, state_next;
  logic [kmna_pkg::CNT_WIDTH-1:0] cnt, cnt_next;
  logic [kmna_pkg::CNT_WIDTH-1:0] kc;
  logic                           accept;

  always_comb begin
    if (active_centers == '0) begin
      kc = kmna_pkg::CNT_WIDTH'(1);
    end else if ({1'b0, active_centers} > (kmna_pkg::AC_WIDTH + 1)'(kmna_pkg::MAX_CENTERS)) begin
      kc = kmna_pkg::CNT_WIDTH'(kmna_pkg::MAX_CENTERS);
    end else begin
      kc = kmna_pkg::CNT_WIDTH'(active_centers);
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd.load_wr   = 1'b0;
    cmd.point_ld  = 1'b0;
    cmd.issue     = 1'b0;
    cmd.issue_idx = cnt[kmna_pkg::ROW_BITS-1:0];
    cmd.out_ld    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == kmna_pkg::FUNC_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.point_ld = 1'b1;
            cnt_next     = '0;
            state_next   = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cnt == kc - kmna_pkg::CNT_WIDTH'(1)) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + kmna_pkg::CNT_WIDTH'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_out_ld_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (status.out_free && !status.pipe_busy))
    else $error("result loaded while the output register was occupied or rows were in flight");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (cnt < kc))
    else $error("row issued beyond the active centre count");

  a_classify_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == kmna_pkg::FUNC_CLASSIFY)) |=> (state == ST_RUN && cnt == '0))
    else $error("classify transaction did not start a row sweep");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    status.pipe_busy |-> !in_ready)
    else $error("input accepted while rows were still in flight");

endmodule
`default_nettype wire

@@ rtl/core/kmeans_nearest_center_assign_unit.sv @@
// Top level of the k-means nearest-centre assignment unit.
// The unit holds up to sixteen cluster centres of eight signed 16-bit coordinates.
// Input transactions (in_valid/in_ready) carry func, center_slot and coord_0..coord_7.
// A load transaction (func 0) writes one centre row in the cycle it is accepted and
// produces no result; the next transaction may follow in the following cycle.
// A classify transaction (func 1) compares the point with centres 0 to k-1, one row
// per cycle over eight parallel lanes, and returns label and min_distance on the
// output channel (out_valid/out_ready). The row sweep makes one centre store read per
// cycle, with k the active centre count; no new input is taken from acceptance until
// the result is presented.
// A finished result sits in an output register, so the next transaction is accepted
// while it waits; a further result waits inside the unit until that register frees.
// The APB-style port holds active_centers (address 0) and active_dims (address 4), which
// the user must write only while the unit is idle; the block does not enforce it. Reset sets
// them to 1 and 8 and empties the pipeline and output register; centre rows are undefined until loaded.
`default_nettype none
module kmeans_nearest_center_assign_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                func,
  input  wire logic [kmna_pkg::SLOT_WIDTH-1:0]     center_slot,
  input  wire logic signed [15:0]                  coord_0,
  input  wire logic signed [15:0]                  coord_1,
  input  wire logic signed [15:0]                  coord_2,
  input  wire logic signed [15:0]                  coord_3,
  input  wire logic signed [15:0]                  coord_4,
  input  wire logic signed [15:0]                  coord_5,
  input  wire logic signed [15:0]                  coord_6,
  input  wire logic signed [15:0]                  coord_7,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [kmna_pkg::LABEL_WIDTH-1:0]    label,
  output logic      [kmna_pkg::DIST_WIDTH-1:0]     min_distance,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [kmna_pkg::ADDR_WIDTH-1:0]     paddr,
  input  wire logic [kmna_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic      [kmna_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                     pready
);

  logic [kmna_pkg::AC_WIDTH-1:0] active_centers;
  logic [kmna_pkg::AD_WIDTH-1:0] active_dims;
  kmna_pkg::ctrl_cmd_t           cmd;
  kmna_pkg::dp_status_t          status;
  kmna_pkg::in_coord_t           coord [kmna_pkg::MAX_DIMS];

  assign coord[0] = coord_0;
  assign coord[1] = coord_1;
  assign coord[2] = coord_2;
  assign coord[3] = coord_3;
  assign coord[4] = coord_4;
  assign coord[5] = coord_5;
  assign coord[6] = coord_6;
  assign coord[7] = coord_7;

  kmna_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .active_centers (active_centers),
    .active_dims    (active_dims)
  );

  kmna_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .active_centers (active_centers),
    .status         (status),
    .cmd            (cmd)
  );

  kmna_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .center_slot    (center_slot),
    .coord          (coord),
    .active_dims    (active_dims),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .label          (label),
    .min_distance   (min_distance)
  );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench of the k-means nearest-centre assignment unit.
module testbench;

  typedef struct packed {
    logic                                                        func;
    logic [kmna_pkg::SLOT_WIDTH-1:0]                             slot;
    logic [kmna_pkg::MAX_DIMS-1:0][kmna_pkg::IN_COORD_WIDTH-1:0] coord;
  } assign_req_t;

  typedef struct packed {
    logic [kmna_pkg::LABEL_WIDTH-1:0] label;
    logic [kmna_pkg::DIST_WIDTH-1:0]  distance;
  } nearest_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum {STYLE_SMALL, STYLE_EXTREME, STYLE_FULL} coord_style_e;

  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 250;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_AC [NUM_PHASES] = '{16, 0, 31, 16, 3, 1, 17, 9};
  localparam int PHASE_AD [NUM_PHASES] = '{8, 1, 15, 0, 8, 8, 9, 5};

  class assign_scoreboard;
    logic [kmna_pkg::COORD_WIDTH-1:0] centre_tab [kmna_pkg::MAX_CENTERS][kmna_pkg::MAX_DIMS];
    logic [kmna_pkg::AC_WIDTH-1:0]    active_centers;
    logic [kmna_pkg::AD_WIDTH-1:0]    active_dims;
    nearest_t                         expected_q [$];
    int                               errors;

    function new();
      active_centers = kmna_pkg::ACTIVE_CENTERS_RESET;
      active_dims    = kmna_pkg::ACTIVE_DIMS_RESET;
      errors         = 0;
    endfunction

    function void note_input(input assign_req_t req);
      int unsigned     k;
      int unsigned     n;
      longint          diff;
      longint unsigned sum;
      longint unsigned best;
      nearest_t        res;
      if (req.func == kmna_pkg::FUNC_LOAD) begin
        if (req.slot < kmna_pkg::MAX_CENTERS) begin
          for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) centre_tab[req.slot][i] = req.coord[i];
        end
        return;
      end
      k = active_centers;
      if (k < 1) k = 1;
      if (k > kmna_pkg::MAX_CENTERS) k = kmna_pkg::MAX_CENTERS;
      n = (active_dims > kmna_pkg::MAX_DIMS) ? kmna_pkg::MAX_DIMS : active_dims;
      best = 0;
      res.label = '0;
      for (int j = 0; j < k; j++) begin
        sum = 0;
        for (int i = 0; i < n; i++) begin
          diff = longint'($signed(req.coord[i])) - longint'($signed(centre_tab[j][i]));
          sum = sum + diff * diff;
          if (sum > kmna_pkg::DIST_MAX) sum = kmna_pkg::DIST_MAX;
        end
        // Strict comparison: on equal distances the lower index is kept.
        if (j == 0 || sum < best) begin
          best = sum;
          res.label = kmna_pkg::LABEL_WIDTH'(j);
        end
      end
      res.distance = kmna_pkg::DIST_WIDTH'(best);
      expected_q.push_back(res);
    endfunction

    function void check_result(input logic [kmna_pkg::LABEL_WIDTH-1:0] label_got,
                               input logic [kmna_pkg::DIST_WIDTH-1:0] dist_got);
      nearest_t exp_res;
      if (expected_q.size() == 0) begin
        $error("Result with no classify transaction outstanding: label %0d, min_distance %0d",
               label_got, dist_got);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (label_got !== exp_res.label) begin
        $error("label: expected %0d, actual %0d", exp_res.label, label_got);
        errors++;
      end
      if (dist_got !== exp_res.distance) begin
        $error("min_distance: expected %0d, actual %0d", exp_res.distance, dist_got);
        errors++;
      end
    endfunction
  endclass

  logic                                                        clk = 1'b0;
  logic                                                        rst = 1'b1;
  logic                                                        in_valid = 1'b0;
  logic                                                        in_ready;
  logic                                                        func_drv = kmna_pkg::FUNC_LOAD;
  logic [kmna_pkg::SLOT_WIDTH-1:0]                             slot_drv = '0;
  logic [kmna_pkg::MAX_DIMS-1:0][kmna_pkg::IN_COORD_WIDTH-1:0] coord_drv = '0;
  logic                                                        out_valid;
  logic                                                        out_ready = 1'b0;
  logic [kmna_pkg::LABEL_WIDTH-1:0]                            label;
  logic [kmna_pkg::DIST_WIDTH-1:0]                             min_distance;
  logic                                                        psel = 1'b0;
  logic                                                        penable = 1'b0;
  logic                                                        pwrite = 1'b0;
  logic [kmna_pkg::ADDR_WIDTH-1:0]                             paddr = '0;
  logic [kmna_pkg::DATA_WIDTH-1:0]                             pwdata = '0;
  logic [kmna_pkg::DATA_WIDTH-1:0]                             prdata;
  logic                                                        pready;

  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  int               rx_hold = 0;
  assign_scoreboard sb;

  kmeans_nearest_center_assign_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func_drv),
    .center_slot  (slot_drv),
    .coord_0      (coord_drv[0]),
    .coord_1      (coord_drv[1]),
    .coord_2      (coord_drv[2]),
    .coord_3      (coord_drv[3]),
    .coord_4      (coord_drv[4]),
    .coord_5      (coord_drv[5]),
    .coord_6      (coord_drv[6]),
    .coord_7      (coord_drv[7]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .label        (label),
    .min_distance (min_distance),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [kmna_pkg::IN_COORD_WIDTH-1:0] rand_coord(input coord_style_e style);
    logic [kmna_pkg::IN_COORD_WIDTH-1:0] v;
    case (style)
      STYLE_SMALL: begin
        v = kmna_pkg::IN_COORD_WIDTH'($urandom_range(6)) - kmna_pkg::IN_COORD_WIDTH'(3);
      end
      STYLE_EXTREME: begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: begin
        v = kmna_pkg::IN_COORD_WIDTH'($urandom);
      end
    endcase
    return v;
  endfunction

  function automatic assign_req_t uniform_req(input logic func,
                                              input logic [kmna_pkg::SLOT_WIDTH-1:0] slot,
                                              input logic [kmna_pkg::IN_COORD_WIDTH-1:0] value);
    assign_req_t req;
    req.func = func;
    req.slot = slot;
    for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) req.coord[i] = value;
    return req;
  endfunction

  // Some random rows copy an existing centre (loads) or sit close to one (classifies), so that
  // ties and near misses are frequent.
  function automatic assign_req_t random_req();
    assign_req_t  req;
    coord_style_e style;
    int unsigned  pick;
    int unsigned  src;
    pick = $urandom_range(99);
    style = (pick < 20) ? STYLE_SMALL : (pick < 35) ? STYLE_EXTREME : STYLE_FULL;
    req.func = ($urandom_range(99) < 35) ? kmna_pkg::FUNC_LOAD : kmna_pkg::FUNC_CLASSIFY;
    req.slot = kmna_pkg::SLOT_WIDTH'($urandom_range(kmna_pkg::MAX_CENTERS - 1));
    src = $urandom_range(kmna_pkg::MAX_CENTERS - 1);
    pick = $urandom_range(99);
    for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) begin
      if (pick < 15) begin
        req.coord[i] = sb.centre_tab[src][i];
        if (req.func == kmna_pkg::FUNC_CLASSIFY) begin
          req.coord[i] = req.coord[i] + rand_coord(STYLE_SMALL);
        end
      end else begin
        req.coord[i] = rand_coord(style);
      end
    end
    return req;
  endfunction

  task automatic send_item(input assign_req_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func_drv  <= req.func;
    slot_drv  <= req.slot;
    coord_drv <= req.coord;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx,
                            input logic [kmna_pkg::DATA_WIDTH-1:0] wdata,
                            output logic [kmna_pkg::DATA_WIDTH-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= kmna_pkg::ADDR_WIDTH'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [kmna_pkg::DATA_WIDTH-1:0] expected_val);
    logic [kmna_pkg::DATA_WIDTH-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== expected_val) begin
      $error("%s: expected %0d, actual %0d",
             (idx == kmna_pkg::REG_ACTIVE_CENTERS) ? "active_centers" : "active_dims",
             expected_val, rd);
      sb.errors++;
    end
  endtask

  task automatic program_regs(input int unsigned centres, input int unsigned dims);
    logic [kmna_pkg::DATA_WIDTH-1:0] rd_dummy;
    apb_access(1'b1, kmna_pkg::REG_ACTIVE_CENTERS, kmna_pkg::DATA_WIDTH'(centres), rd_dummy);
    apb_access(1'b1, kmna_pkg::REG_ACTIVE_DIMS, kmna_pkg::DATA_WIDTH'(dims), rd_dummy);
    sb.active_centers = kmna_pkg::AC_WIDTH'(centres);
    sb.active_dims    = kmna_pkg::AD_WIDTH'(dims);
    check_reg(kmna_pkg::REG_ACTIVE_CENTERS, kmna_pkg::DATA_WIDTH'(sb.active_centers));
    check_reg(kmna_pkg::REG_ACTIVE_DIMS, kmna_pkg::DATA_WIDTH'(sb.active_dims));
  endtask

  task automatic wait_results();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(label, min_distance);
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    assign_req_t req;
    idle_mode_e  mode;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_reg(kmna_pkg::REG_ACTIVE_CENTERS, kmna_pkg::DATA_WIDTH'(kmna_pkg::ACTIVE_CENTERS_RESET));
    check_reg(kmna_pkg::REG_ACTIVE_DIMS, kmna_pkg::DATA_WIDTH'(kmna_pkg::ACTIVE_DIMS_RESET));

    // With one active centre, only centre 0 needs to be loaded before classifying.
    send_item(uniform_req(kmna_pkg::FUNC_LOAD, '0, 16'h7FFF));
    send_item(uniform_req(kmna_pkg::FUNC_CLASSIFY, '0, 16'h8000));
    send_item(uniform_req(kmna_pkg::FUNC_CLASSIFY, '0, 16'h7FFF));
    send_item(uniform_req(kmna_pkg::FUNC_LOAD, '0, 16'h8000));
    send_item(uniform_req(kmna_pkg::FUNC_CLASSIFY, '0, 16'h7FFF));
    for (int s = 1; s < kmna_pkg::MAX_CENTERS; s++) begin
      req = uniform_req(kmna_pkg::FUNC_LOAD, kmna_pkg::SLOT_WIDTH'(s), '0);
      for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) begin
        if (s == 2) req.coord[i] = sb.centre_tab[1][i];
        else if (s == 3) req.coord[i] = (i % 2 == 1) ? 16'h8000 : 16'h7FFF;
        else req.coord[i] = rand_coord(STYLE_FULL);
      end
      send_item(req);
    end
    in_valid <= 1'b0;
    wait_results();
    program_regs(kmna_pkg::MAX_CENTERS, kmna_pkg::MAX_DIMS);

    // Centres 1 and 2 are identical, so this point must be labelled 1.
    req = uniform_req(kmna_pkg::FUNC_CLASSIFY, '0, '0);
    for (int i = 0; i < kmna_pkg::MAX_DIMS; i++) req.coord[i] = sb.centre_tab[1][i];
    send_item(req);
    send_item(uniform_req(kmna_pkg::FUNC_CLASSIFY, '0, '0));
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results();
      program_regs(PHASE_AC[p], PHASE_AD[p]);
      mode = idle_mode_e'(p % 4);
      tx_idle_pct  = (mode == IDLE_SENDER) ? 55 : (mode == IDLE_BOTH) ? 26 : 0;
      rx_stall_pct = (mode == IDLE_RECEIVER) ? 55 : (mode == IDLE_BOTH) ? 26 : 0;
      if (mode == IDLE_NONE && p > 0) rx_hold = HOLD_CYCLES;
      for (int t = 0; t < PHASE_ITEMS; t++) send_item(random_req());
      in_valid <= 1'b0;
    end
    wait_results();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
